FILE: hw/rtl/sfcs_pkg.sv
// sfcs_pkg: shared types and constants of the spi flash command sequencer
// used by sfcs_front, sfcs_queue, sfcs_back and the top level
`timescale 1ns / 1ps

package sfcs_pkg;

  // default geometry and queue depth, all powers of two
  localparam int unsigned PAGE_BYTES_DEF   = 256;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  // request modes
  typedef enum logic [3:0] {
    MODE_RDSR      = 4'd0,
    MODE_WRSR      = 4'd1,
    MODE_WREN      = 4'd2,
    MODE_WRDI      = 4'd3,
    MODE_ID        = 4'd4,
    MODE_RDSTART   = 4'd5,
    MODE_RDBYTE    = 4'd6,
    MODE_RDEND     = 4'd7,
    MODE_PGSTART   = 4'd8,
    MODE_PGBYTE    = 4'd9,
    MODE_PGEND     = 4'd10,
    MODE_SECERASE  = 4'd11,
    MODE_CHIPERASE = 4'd12,
    MODE_PDOWN     = 4'd13,
    MODE_WAKE      = 4'd14,
    MODE_EN4BYTE   = 4'd15
  } mode_e;

  // bus actions
  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_POLL  = 2'd2,
    ACT_DELAY = 2'd3
  } action_e;

  // flash opcodes
  localparam logic [7:0] OP_WREN    = 8'h06;
  localparam logic [7:0] OP_WRDI    = 8'h04;
  localparam logic [7:0] OP_WRSR    = 8'h01;
  localparam logic [7:0] OP_RDSR    = 8'h05;
  localparam logic [7:0] OP_PP      = 8'h02;
  localparam logic [7:0] OP_READ    = 8'h03;
  localparam logic [7:0] OP_SE      = 8'h20;
  localparam logic [7:0] OP_CE      = 8'hC7;
  localparam logic [7:0] OP_ID      = 8'h90;
  localparam logic [7:0] OP_PD      = 8'hB9;
  localparam logic [7:0] OP_RPD     = 8'hAB;
  localparam logic [7:0] OP_EN4B    = 8'hB7;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;

  // action slots of one request, emitted in index order
  localparam int unsigned NUM_SLOTS = 18;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned NUM_BYTES = 5;

  localparam logic [SLOT_W-1:0] SLOT_CLOSE_RAISE = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_CLOSE_POLL  = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_WREN_OP     = 5'd2;
  localparam logic [SLOT_W-1:0] SLOT_WREN_RAISE  = 5'd3;
  localparam logic [SLOT_W-1:0] SLOT_WREN_POLL   = 5'd4;
  localparam logic [SLOT_W-1:0] SLOT_OPCODE      = 5'd5;
  localparam logic [SLOT_W-1:0] SLOT_ADDR3       = 5'd6;
  localparam logic [SLOT_W-1:0] SLOT_ADDR2       = 5'd7;
  localparam logic [SLOT_W-1:0] SLOT_ADDR1       = 5'd8;
  localparam logic [SLOT_W-1:0] SLOT_ADDR0       = 5'd9;
  localparam logic [SLOT_W-1:0] SLOT_BYTE0       = 5'd10;
  localparam logic [SLOT_W-1:0] SLOT_BYTE1       = 5'd11;
  localparam logic [SLOT_W-1:0] SLOT_BYTE2       = 5'd12;
  localparam logic [SLOT_W-1:0] SLOT_BYTE3       = 5'd13;
  localparam logic [SLOT_W-1:0] SLOT_BYTE4       = 5'd14;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_RAISE  = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_POLL   = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_DELAY       = 5'd17;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  localparam slot_mask_t M_CLOSE = slot_mask_t'(3) << SLOT_CLOSE_RAISE;
  localparam slot_mask_t M_WREN  = slot_mask_t'(3) << SLOT_WREN_OP;
  localparam slot_mask_t M_WPOLL = slot_mask_t'(1) << SLOT_WREN_POLL;
  localparam slot_mask_t M_OP    = slot_mask_t'(1) << SLOT_OPCODE;
  localparam slot_mask_t M_ADDR3 = slot_mask_t'(1) << SLOT_ADDR3;
  localparam slot_mask_t M_ADDR  = slot_mask_t'(7) << SLOT_ADDR2;
  localparam slot_mask_t M_BYTE0 = slot_mask_t'(1) << SLOT_BYTE0;
  localparam slot_mask_t M_BYTES = slot_mask_t'(31) << SLOT_BYTE0;
  localparam slot_mask_t M_RAISE = slot_mask_t'(1) << SLOT_TAIL_RAISE;
  localparam slot_mask_t M_TAIL  = slot_mask_t'(3) << SLOT_TAIL_RAISE;
  localparam slot_mask_t M_DELAY = slot_mask_t'(1) << SLOT_DELAY;

  // one classified request as it travels from front to back
  typedef struct packed {
    slot_mask_t                      mask;
    logic [7:0]                      opcode;
    logic [31:0]                     addr;
    logic [NUM_BYTES-1:0][7:0]       bytes;
    logic [NUM_BYTES-1:0]            caps;
    logic [7:0]                      delay;
  } desc_t;

endpackage

FILE: hw/rtl/sfcs_queue.sv
// sfcs_queue: short request queue between front and back
// depends on sfcs_pkg (desc_t); depth must be a power of two
`timescale 1ns / 1ps

module sfcs_queue import sfcs_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/sfcs_front.sv
// sfcs_front: accepts requests, tracks the running page address and builds
// the action slot mask of each request; depends on sfcs_pkg
`timescale 1ns / 1ps

module sfcs_front import sfcs_pkg::*; #(
  parameter int unsigned PageBytes   = PAGE_BYTES_DEF,
  parameter int unsigned SectorBytes = SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  data_i,
  input  logic        four_byte_i,
  input  logic [7:0]  wake_delay_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output desc_t       desc_o
);

  localparam int unsigned PageW      = $clog2(PageBytes);
  localparam logic [31:0] SectorMask = ~(32'(SectorBytes) - 32'd1);

  logic [31:0] run_q, run_d;
  logic        open_q, open_d;
  logic [31:0] run_inc;
  logic        accept;
  slot_mask_t  addr_m;
  mode_e       mode;

  assign ready_o = !queue_full_i;
  assign accept  = valid_i && ready_o;
  assign mode    = mode_e'(mode_i);
  assign run_inc = run_q + 32'd1;
  assign addr_m  = (four_byte_i ? M_ADDR3 : '0) | M_ADDR;
  assign push_o  = accept && (desc_o.mask != '0);

  // classify the request into slots
  always_comb begin
    desc_o        = '0;
    desc_o.addr   = address_i;
    desc_o.delay  = wake_delay_i;
    run_d         = run_q;
    open_d        = open_q;
    if (open_q && mode != MODE_PGSTART && mode != MODE_PGBYTE && mode != MODE_PGEND) begin
      // request dropped, only the open page is closed
      desc_o.mask = M_CLOSE;
      open_d      = 1'b0;
    end else begin
      case (mode)
        MODE_RDSR: begin
          desc_o.mask     = M_OP | M_BYTE0 | M_RAISE;
          desc_o.opcode   = OP_RDSR;
          desc_o.bytes[0] = DUMMY_BYTE;
          desc_o.caps[0]  = 1'b1;
        end
        MODE_WRSR: begin
          desc_o.mask     = M_OP | M_BYTE0 | M_RAISE;
          desc_o.opcode   = OP_WRSR;
          desc_o.bytes[0] = data_i;
        end
        MODE_WREN: begin
          desc_o.mask   = M_OP | M_RAISE;
          desc_o.opcode = OP_WREN;
        end
        MODE_WRDI: begin
          desc_o.mask   = M_OP | M_RAISE;
          desc_o.opcode = OP_WRDI;
        end
        MODE_ID: begin
          desc_o.mask     = M_OP | M_BYTES | M_RAISE;
          desc_o.opcode   = OP_ID;
          desc_o.bytes[3] = DUMMY_BYTE;
          desc_o.bytes[4] = DUMMY_BYTE;
          desc_o.caps[3]  = 1'b1;
          desc_o.caps[4]  = 1'b1;
        end
        MODE_RDSTART: begin
          desc_o.mask   = M_OP | addr_m;
          desc_o.opcode = OP_READ;
        end
        MODE_RDBYTE: begin
          desc_o.mask     = M_BYTE0;
          desc_o.bytes[0] = DUMMY_BYTE;
          desc_o.caps[0]  = 1'b1;
        end
        MODE_RDEND: begin
          desc_o.mask = M_RAISE;
        end
        MODE_PGSTART: begin
          desc_o.mask   = (open_q ? M_CLOSE : '0) | M_WREN | M_OP | addr_m;
          desc_o.opcode = OP_PP;
          run_d         = address_i;
          open_d        = 1'b1;
        end
        MODE_PGBYTE: begin
          desc_o.mask     = M_BYTE0;
          desc_o.bytes[0] = data_i;
          if (!open_q) begin
            // reopen at the running address
            desc_o.mask   = M_WREN | M_OP | addr_m | M_BYTE0;
            desc_o.opcode = OP_PP;
            desc_o.addr   = run_q;
          end
          run_d = run_inc;
          if (run_inc[PageW-1:0] == '0) begin
            // page boundary reached
            desc_o.mask = desc_o.mask | M_TAIL;
            open_d      = 1'b0;
          end else begin
            open_d = 1'b1;
          end
        end
        MODE_PGEND: begin
          desc_o.mask = open_q ? M_CLOSE : '0;
          open_d      = 1'b0;
        end
        MODE_SECERASE: begin
          desc_o.mask   = M_WREN | M_WPOLL | M_OP | addr_m | M_TAIL;
          desc_o.opcode = OP_SE;
          desc_o.addr   = address_i & SectorMask;
        end
        MODE_CHIPERASE: begin
          desc_o.mask   = M_WREN | M_WPOLL | M_OP | M_TAIL;
          desc_o.opcode = OP_CE;
        end
        MODE_PDOWN: begin
          desc_o.mask   = M_OP | M_RAISE | M_DELAY;
          desc_o.opcode = OP_PD;
        end
        MODE_WAKE: begin
          desc_o.mask   = M_OP | M_RAISE | M_DELAY;
          desc_o.opcode = OP_RPD;
        end
        default: begin
          desc_o.mask   = M_WREN | M_WPOLL | M_OP | M_TAIL;
          desc_o.opcode = OP_EN4B;
        end
      endcase
    end
  end

  // page tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      open_q <= 1'b0;
    end else if (accept) begin
      run_q  <= run_d;
      open_q <= open_d;
    end
  end

endmodule

FILE: hw/rtl/sfcs_back.sv
// sfcs_back: walks the current request's slot mask and emits one bus
// action per unstalled cycle into an output register; uses sfcs_pkg
`timescale 1ns / 1ps

module sfcs_back import sfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_t      head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [1:0] action_o,
  output logic [7:0] out_byte_o,
  output logic       capture_o,
  output logic       last_o
);

  desc_t             cur_q;
  slot_mask_t        mask_q, mask_d;
  slot_mask_t        low_bit;
  logic [SLOT_W-1:0] slot;
  logic              emit, is_last;
  action_e           act;
  logic [7:0]        byte_v;
  logic              cap_v;

  logic              out_valid_q;
  logic [1:0]        out_act_q;
  logic [7:0]        out_byte_q;
  logic              out_cap_q;
  logic              out_last_q;

  assign low_bit = mask_q & (~mask_q + slot_mask_t'(1));
  assign is_last = (mask_q & (mask_q - slot_mask_t'(1))) == '0;
  assign emit    = (mask_q != '0) && (!out_valid_q || ready_i);
  assign pop_o   = !empty_i && ((mask_q == '0) || (emit && is_last));

  // index of the lowest pending slot
  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  // action of the selected slot
  always_comb begin
    act    = ACT_SEND;
    byte_v = '0;
    cap_v  = 1'b0;
    case (slot)
      SLOT_CLOSE_RAISE, SLOT_WREN_RAISE, SLOT_TAIL_RAISE: act = ACT_RAISE;
      SLOT_CLOSE_POLL, SLOT_WREN_POLL, SLOT_TAIL_POLL:    act = ACT_POLL;
      SLOT_WREN_OP: byte_v = OP_WREN;
      SLOT_OPCODE:  byte_v = cur_q.opcode;
      SLOT_ADDR3:   byte_v = cur_q.addr[31:24];
      SLOT_ADDR2:   byte_v = cur_q.addr[23:16];
      SLOT_ADDR1:   byte_v = cur_q.addr[15:8];
      SLOT_ADDR0:   byte_v = cur_q.addr[7:0];
      SLOT_BYTE0: begin
        byte_v = cur_q.bytes[0];
        cap_v  = cur_q.caps[0];
      end
      SLOT_BYTE1: begin
        byte_v = cur_q.bytes[1];
        cap_v  = cur_q.caps[1];
      end
      SLOT_BYTE2: begin
        byte_v = cur_q.bytes[2];
        cap_v  = cur_q.caps[2];
      end
      SLOT_BYTE3: begin
        byte_v = cur_q.bytes[3];
        cap_v  = cur_q.caps[3];
      end
      SLOT_BYTE4: begin
        byte_v = cur_q.bytes[4];
        cap_v  = cur_q.caps[4];
      end
      SLOT_DELAY: begin
        act    = ACT_DELAY;
        byte_v = cur_q.delay;
      end
      default: act = ACT_SEND;
    endcase
  end

  // pending slots of the current request
  always_comb begin
    mask_d = mask_q;
    if (pop_o) begin
      mask_d = head_i.mask;
    end else if (emit) begin
      mask_d = mask_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (emit) begin
      out_act_q  <= act;
      out_byte_q <= byte_v;
      out_cap_q  <= cap_v;
      out_last_q <= is_last;
    end
  end

  assign valid_o    = out_valid_q;
  assign action_o   = out_act_q;
  assign out_byte_o = out_byte_q;
  assign capture_o  = out_cap_q;
  assign last_o     = out_last_q;

endmodule

FILE: hw/rtl/spi_flash_command_sequencer_top.sv
// spi_flash_command_sequencer_top: spi nor flash command sequencer
// depends on sfcs_pkg, sfcs_front, sfcs_queue and sfcs_back
//
// Usage: requests come in on the s_axis channel (mode, address, data) and
// each one turns into one to ten bus actions on the m_axis channel: send a
// byte with chip select low, raise chip select, poll until not busy, or a
// fixed delay. tlast marks the final action of a request; a program end
// with no page open makes no action at all. Registers four_byte_address
// (0x0) and wake_delay_us (0x4) sit on the APB port; the user must write
// them only while the block is idle, which the block does not enforce.
// Timing: the front takes one request per clock while the queue has room,
// so several requests can follow back to back. The first action of a
// request passes the queue, the back's mask and current-request registers
// and the output register; the back then emits one action per clock while
// m_axis is not stalled; the action slot walker in the back sets that rate.
// Stalls: when m_axis_tready is low the output register holds, the back
// halts and the queue fills; s_axis_tready drops once it is full.
// Reset: the running address clears, no page is open, 24-bit addressing,
// a wake delay of 3, queue and output empty.
`timescale 1ns / 1ps

module spi_flash_command_sequencer_top import sfcs_pkg::*; #(
  parameter int unsigned PageBytes   = PAGE_BYTES_DEF,
  parameter int unsigned SectorBytes = SECTOR_BYTES_DEF,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // mode[3:0], address[35:4], data[43:36], zero fill
  // action channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic [2:0]  m_axis_tuser,   // action[1:0], capture[2]
  output logic        m_axis_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        four_byte_q;
  logic [7:0]  wake_delay_q;
  logic        cfg_wr;
  logic        push, pop, full, empty;
  desc_t       push_desc, head_desc;
  logic [1:0]  action;
  logic        capture;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {24'd0, wake_delay_q} : {31'd0, four_byte_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_byte_q  <= 1'b0;
      wake_delay_q <= 8'd3;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        wake_delay_q <= pwdata[7:0];
      end else begin
        four_byte_q <= pwdata[0];
      end
    end
  end

  // request classification
  sfcs_front #(
    .PageBytes   (PageBytes),
    .SectorBytes (SectorBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .mode_i       (s_axis_tdata[3:0]),
    .address_i    (s_axis_tdata[35:4]),
    .data_i       (s_axis_tdata[43:36]),
    .four_byte_i  (four_byte_q),
    .wake_delay_i (wake_delay_q),
    .queue_full_i (full),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  // decoupling queue
  sfcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .head_o      (head_desc),
    .full_o      (full),
    .empty_o     (empty)
  );

  // action generation
  sfcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_desc),
    .empty_i    (empty),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .action_o   (action),
    .out_byte_o (m_axis_tdata),
    .capture_o  (capture),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tuser = {capture, action};

endmodule

FILE: tb/sfcs_action_checker.sv
// sfcs_action_checker: watches the request, action and register channels of the
// spi flash command sequencer, predicts every bus action and compares it
// depends on sfcs_pkg for modes, actions, opcodes and default geometry
`timescale 1ns / 1ps

module sfcs_action_checker import sfcs_pkg::*; #(
  parameter logic [2:0]  AddrFourByte  = 3'h0,
  parameter logic [2:0]  AddrWakeDelay = 3'h4,
  parameter int unsigned PageBytes     = PAGE_BYTES_DEF,
  parameter int unsigned SectorBytes   = SECTOR_BYTES_DEF,
  parameter int unsigned PrintLimit    = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    action_e    act;
    logic [7:0] out_byte;
    logic       capture;
    logic       last;
  } bus_action_t;

  bus_action_t expected_actions[$];
  bus_action_t request_actions[$];

  // mirror of the block's registers and program state
  logic        four_byte_q  = 1'b0;
  logic [7:0]  wake_delay_q = 8'd3;
  logic [31:0] run_addr_q   = '0;
  logic        page_open_q  = 1'b0;

  int fail_total = 0;
  int pending_q  = 0;

  assign fail_count_o = fail_total;
  assign pending_o    = pending_q;

  task automatic flag_mismatch(input string msg);
    if (fail_total < PrintLimit) $display("%0t ns: %s", $time, msg);
    fail_total++;
  endtask

  function automatic void emit(input action_e act, input logic [7:0] b, input logic cap);
    bus_action_t a;
    a.act      = act;
    a.out_byte = b;
    a.capture  = cap;
    a.last     = 1'b0;
    request_actions.push_back(a);
  endfunction

  // address bytes msb first, three or four of them
  function automatic void emit_address(input logic [31:0] addr);
    if (four_byte_q) emit(ACT_SEND, addr[31:24], 1'b0);
    emit(ACT_SEND, addr[23:16], 1'b0);
    emit(ACT_SEND, addr[15:8], 1'b0);
    emit(ACT_SEND, addr[7:0], 1'b0);
  endfunction

  function automatic void close_page();
    emit(ACT_RAISE, 8'h00, 1'b0);
    emit(ACT_POLL, 8'h00, 1'b0);
    page_open_q = 1'b0;
  endfunction

  function automatic void open_page();
    emit(ACT_SEND, OP_WREN, 1'b0);
    emit(ACT_RAISE, 8'h00, 1'b0);
    emit(ACT_SEND, OP_PP, 1'b0);
    emit_address(run_addr_q);
    page_open_q = 1'b1;
  endfunction

  function automatic void enable_and_wait();
    emit(ACT_SEND, OP_WREN, 1'b0);
    emit(ACT_RAISE, 8'h00, 1'b0);
    emit(ACT_POLL, 8'h00, 1'b0);
  endfunction

  // expected bus actions of one request, appended to the expected store
  function automatic void sequence_request(input mode_e mode, input logic [31:0] addr,
                                           input logic [7:0] data);
    bus_action_t tail_act;
    request_actions.delete();
    if (page_open_q && mode != MODE_PGSTART && mode != MODE_PGBYTE && mode != MODE_PGEND) begin
      // any other request only closes the open page and is dropped
      close_page();
    end else begin
      case (mode)
        MODE_RDSR: begin
          emit(ACT_SEND, OP_RDSR, 1'b0);
          emit(ACT_SEND, DUMMY_BYTE, 1'b1);
          emit(ACT_RAISE, 8'h00, 1'b0);
        end
        MODE_WRSR: begin
          emit(ACT_SEND, OP_WRSR, 1'b0);
          emit(ACT_SEND, data, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
        end
        MODE_WREN: begin
          emit(ACT_SEND, OP_WREN, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
        end
        MODE_WRDI: begin
          emit(ACT_SEND, OP_WRDI, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
        end
        MODE_ID: begin
          emit(ACT_SEND, OP_ID, 1'b0);
          emit(ACT_SEND, 8'h00, 1'b0);
          emit(ACT_SEND, 8'h00, 1'b0);
          emit(ACT_SEND, 8'h00, 1'b0);
          emit(ACT_SEND, DUMMY_BYTE, 1'b1);
          emit(ACT_SEND, DUMMY_BYTE, 1'b1);
          emit(ACT_RAISE, 8'h00, 1'b0);
        end
        MODE_RDSTART: begin
          emit(ACT_SEND, OP_READ, 1'b0);
          emit_address(addr);
        end
        MODE_RDBYTE: emit(ACT_SEND, DUMMY_BYTE, 1'b1);
        MODE_RDEND:  emit(ACT_RAISE, 8'h00, 1'b0);
        MODE_PGSTART: begin
          if (page_open_q) close_page();
          run_addr_q = addr;
          open_page();
        end
        MODE_PGBYTE: begin
          if (!page_open_q) open_page();
          emit(ACT_SEND, data, 1'b0);
          run_addr_q = run_addr_q + 32'd1;
          if ((run_addr_q % PageBytes) == 0) close_page();
        end
        MODE_PGEND: begin
          if (page_open_q) close_page();
        end
        MODE_SECERASE: begin
          enable_and_wait();
          emit(ACT_SEND, OP_SE, 1'b0);
          emit_address(addr - (addr % SectorBytes));
          emit(ACT_RAISE, 8'h00, 1'b0);
          emit(ACT_POLL, 8'h00, 1'b0);
        end
        MODE_CHIPERASE: begin
          enable_and_wait();
          emit(ACT_SEND, OP_CE, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
          emit(ACT_POLL, 8'h00, 1'b0);
        end
        MODE_PDOWN: begin
          emit(ACT_SEND, OP_PD, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
          emit(ACT_DELAY, wake_delay_q, 1'b0);
        end
        MODE_WAKE: begin
          emit(ACT_SEND, OP_RPD, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
          emit(ACT_DELAY, wake_delay_q, 1'b0);
        end
        default: begin
          // enter 4-byte mode leaves the address width register alone
          enable_and_wait();
          emit(ACT_SEND, OP_EN4B, 1'b0);
          emit(ACT_RAISE, 8'h00, 1'b0);
          emit(ACT_POLL, 8'h00, 1'b0);
        end
      endcase
    end
    if (request_actions.size() > 0) begin
      tail_act = request_actions.pop_back();
      tail_act.last = 1'b1;
      request_actions.push_back(tail_act);
    end
    foreach (request_actions[i]) expected_actions.push_back(request_actions[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_action_t want;
    if (!rst_ni) begin
      four_byte_q  = 1'b0;
      wake_delay_q = 8'd3;
      run_addr_q   = '0;
      page_open_q  = 1'b0;
      expected_actions.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrFourByte) four_byte_q = pwdata[0];
        else if (paddr == AddrWakeDelay) wake_delay_q = pwdata[7:0];
      end
      // compare each accepted action with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_actions.size() == 0) begin
          flag_mismatch($sformatf("unexpected action %0d byte %02h", m_axis_tuser[1:0],
                                  m_axis_tdata));
        end else begin
          want = expected_actions.pop_front();
          if (m_axis_tuser[1:0] != want.act)
            flag_mismatch($sformatf("action got %0d want %0d", m_axis_tuser[1:0], want.act));
          if (m_axis_tdata != want.out_byte)
            flag_mismatch($sformatf("out_byte got %02h want %02h", m_axis_tdata,
                                    want.out_byte));
          if (m_axis_tuser[2] != want.capture)
            flag_mismatch($sformatf("capture got %0b want %0b", m_axis_tuser[2],
                                    want.capture));
          if (m_axis_tlast != want.last)
            flag_mismatch($sformatf("last got %0b want %0b", m_axis_tlast, want.last));
        end
      end
      // predict accepted requests
      if (s_axis_tvalid && s_axis_tready)
        sequence_request(mode_e'(s_axis_tdata[3:0]), s_axis_tdata[35:4], s_axis_tdata[43:36]);
    end
    pending_q = expected_actions.size();
  end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for spi_flash_command_sequencer_top
// depends on sfcs_pkg, the block itself and sfcs_action_checker
`timescale 1ns / 1ps

module tb import sfcs_pkg::*; ();

  localparam logic [2:0]  ADDR_FOUR_BYTE  = 3'h0;
  localparam logic [2:0]  ADDR_WAKE_DELAY = 3'h4;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned SQUEEZE_CYCLES  = 150;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned PHASE_ITEMS     = 90;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int action_pending;
  int items_sent   = 0;
  int idle_cycles  = 0;
  bit gaps_on      = 1'b1;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  spi_flash_command_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  sfcs_action_checker #(
    .AddrFourByte  (ADDR_FOUR_BYTE),
    .AddrWakeDelay (ADDR_WAKE_DELAY)
  ) action_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (action_pending)
  );

  // watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // action receiver: random stalls, one long hold-off on request
  initial begin
    int pick;
    int len;
    bit ready;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeeze_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 55) begin
          ready = 1'b1;
          len   = $urandom_range(1, 8);
        end else if (pick < 93) begin
          ready = 1'b0;
          len   = $urandom_range(1, 3);
        end else begin
          ready = 1'b0;
          len   = $urandom_range(10, 40);
        end
        m_axis_tready <= ready;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // offer one request after a random gap and hold it until taken
  task automatic offer(input mode_e mode, input logic [31:0] addr, input logic [7:0] data);
    int pick;
    int gap;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) gap = $urandom_range(8, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, data, addr, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and let every expected action drain, plus the no-action tail
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (action_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed program and read runs, some single commands and noise
  task automatic random_phase(input int count);
    int          target;
    int          pick;
    int          n;
    logic [31:0] addr;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        addr = $urandom();
        if ($urandom_range(0, 1)) addr[7:0] = 8'($urandom_range(200, 255));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 24);
        offer(MODE_PGSTART, addr, 8'($urandom()));
        repeat (n) offer(MODE_PGBYTE, $urandom(), 8'($urandom()));
        if ($urandom_range(0, 99) < 80) offer(MODE_PGEND, $urandom(), 8'($urandom()));
      end else if (pick < 60) begin
        offer(MODE_RDSTART, $urandom(), 8'($urandom()));
        n = $urandom_range(1, 6);
        repeat (n) offer(MODE_RDBYTE, $urandom(), 8'($urandom()));
        offer(MODE_RDEND, $urandom(), 8'($urandom()));
      end else if (pick < 75) begin
        case ($urandom_range(0, 5))
          0:       offer(MODE_SECERASE, $urandom(), 8'($urandom()));
          1:       offer(MODE_CHIPERASE, $urandom(), 8'($urandom()));
          2:       offer(MODE_PDOWN, $urandom(), 8'($urandom()));
          3:       offer(MODE_WAKE, $urandom(), 8'($urandom()));
          4:       offer(MODE_WRSR, $urandom(), 8'($urandom()));
          default: offer(MODE_EN4BYTE, $urandom(), 8'($urandom()));
        endcase
      end else begin
        offer(mode_e'($urandom_range(0, 15)), $urandom(), 8'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode, field extremes and the page corner cases
    write_reg(ADDR_FOUR_BYTE, 32'd0);
    write_reg(ADDR_WAKE_DELAY, 32'd0);
    offer(MODE_RDSR, 32'h0, 8'h00);
    offer(MODE_WRSR, 32'hFFFF_FFFF, 8'hFF);
    offer(MODE_WREN, 32'h0, 8'h00);
    offer(MODE_WRDI, 32'h0, 8'h00);
    offer(MODE_ID, 32'h0, 8'h00);
    offer(MODE_RDSTART, 32'hFFFF_FFFF, 8'h00);
    offer(MODE_RDBYTE, 32'h0, 8'h00);
    offer(MODE_RDEND, 32'h0, 8'h00);
    // read bytes and read end with no read start
    offer(MODE_RDBYTE, 32'h0, 8'h00);
    offer(MODE_RDEND, 32'h0, 8'h00);
    // program end with no page open makes nothing
    offer(MODE_PGEND, 32'h0, 8'h00);
    offer(MODE_PGSTART, 32'h0000_00FE, 8'h00);
    offer(MODE_PGBYTE, 32'h0, 8'h00);
    offer(MODE_PGBYTE, 32'h0, 8'hFF);
    // page byte with no page open reopens at the running address
    offer(MODE_PGBYTE, 32'h0, 8'hA5);
    // program start with a page open closes and reopens
    offer(MODE_PGSTART, 32'h0000_1234, 8'h00);
    // any other request with a page open only closes it
    offer(MODE_WREN, 32'h0, 8'h00);
    // running address wraps past the top
    offer(MODE_PGSTART, 32'hFFFF_FFFF, 8'h00);
    offer(MODE_PGBYTE, 32'h0, 8'h5A);
    offer(MODE_SECERASE, 32'hFFFF_FFFF, 8'h00);
    offer(MODE_CHIPERASE, 32'h0, 8'h00);
    offer(MODE_PDOWN, 32'h0, 8'h00);
    offer(MODE_WAKE, 32'h0, 8'h00);
    offer(MODE_EN4BYTE, 32'h0, 8'h00);
    settle();

    // 4-byte addresses, longest delay, one long receiver hold-off
    write_reg(ADDR_FOUR_BYTE, 32'd1);
    write_reg(ADDR_WAKE_DELAY, 32'd255);
    squeeze_req = 1'b1;
    random_phase(PHASE_ITEMS);
    settle();

    // no idling on either side
    write_reg(ADDR_FOUR_BYTE, 32'd0);
    write_reg(ADDR_WAKE_DELAY, 32'($urandom_range(1, 254)));
    gaps_on = 1'b0;
    random_phase(PHASE_ITEMS);
    settle();

    gaps_on = 1'b1;
    write_reg(ADDR_FOUR_BYTE, 32'd1);
    write_reg(ADDR_WAKE_DELAY, 32'd0);
    random_phase(PHASE_ITEMS);
    settle();

    write_reg(ADDR_FOUR_BYTE, 32'hFFFF_FFFE);
    write_reg(ADDR_WAKE_DELAY, $urandom());
    random_phase(PHASE_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
